/* src/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define HBH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define HBH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hbh_pkg.sv */
// Types and fixed constants of the block histogram unit.
package hbh_pkg;

   localparam int unsigned CELLS_PER_BLOCK = 4;
   localparam int unsigned FULL_TURN = 23040;
   localparam int unsigned SUM_W = 20;
   localparam int unsigned POS_W = 6;
   localparam int unsigned ID_W = 5;
   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned RSP_DEPTH = 4;

   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_DESC = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_DESC = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] row;
      logic [5:0] col;
      logic [15:0] magnitude;
      logic [14:0] angle;
      logic [ID_W-1:0] slot;
      logic [31:0] desc;
   } cmd_type;

   typedef struct packed {
      logic [SUM_W-1:0] feature_sum;
      logic [POS_W-1:0] feature_pos;
      logic [ID_W-1:0] block_id;
      logic status;
      logic last;
   } rsp_type;

endpackage

/* src/hog_block_histogram.sv */
// Block histogram unit: the engine writes each pixel straight from its idle state, and a
// compute request reads the gradient window through its single read port, one pixel per
// cycle, and, when the result queue drains freely, sends one result per cycle out of the
// bin sums; an invalid descriptor is answered with an error result. Requests enter a
// four-entry queue in front of the engine, so a burst of requests is taken one per cycle
// until it fills.
module hog_block_histogram #(
   parameter int unsigned IMAGE_SIZE = 64,
   parameter int unsigned CELL_EDGE = 4,
   parameter int unsigned NUM_BINS = 10,
   parameter int unsigned MAX_BLOCKS = 32
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [1:0] req_op,
   input logic [5:0] req_pixel_row,
   input logic [5:0] req_pixel_col,
   input logic [15:0] req_magnitude,
   input logic [14:0] req_angle,
   input logic [4:0] req_block_slot,
   input logic [7:0] req_cell_row,
   input logic [7:0] req_cell_col,
   input logic [7:0] req_cells_high,
   input logic [7:0] req_cells_wide,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic [19:0] rsp_feature_sum,
   output logic [5:0] rsp_feature_pos,
   output logic [4:0] rsp_block_id,
   output logic rsp_status,
   output logic rsp_last
);

   hbh_pkg::cmd_type front_cmd, queue_cmd;
   hbh_pkg::rsp_type back_rsp, out_rsp;
   logic front_push, cmd_full, cmd_empty, cmd_pop;
   logic back_push, rsp_full;

   hbh_front #(
      .IMAGE_SIZE(IMAGE_SIZE),
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_front (
      .req_push(req_push),
      .queue_full(cmd_full),
      .req_op(req_op),
      .req_pixel_row(req_pixel_row),
      .req_pixel_col(req_pixel_col),
      .req_magnitude(req_magnitude),
      .req_angle(req_angle),
      .req_block_slot(req_block_slot),
      .req_cell_row(req_cell_row),
      .req_cell_col(req_cell_col),
      .req_cells_high(req_cells_high),
      .req_cells_wide(req_cells_wide),
      .cmd_push(front_push),
      .cmd(front_cmd)
   );

   hbh_fifo #(
      .DEPTH(hbh_pkg::CMD_DEPTH),
      .item_type(hbh_pkg::cmd_type)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(front_push),
      .push_data(front_cmd),
      .full(cmd_full),
      .pop(cmd_pop),
      .pop_data(queue_cmd),
      .empty(cmd_empty)
   );

   hbh_back #(
      .IMAGE_SIZE(IMAGE_SIZE),
      .CELL_EDGE(CELL_EDGE),
      .NUM_BINS(NUM_BINS),
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_empty(cmd_empty),
      .cmd(queue_cmd),
      .cmd_pop(cmd_pop),
      .rsp_full(rsp_full),
      .rsp_push(back_push),
      .rsp(back_rsp)
   );

   hbh_fifo #(
      .DEPTH(hbh_pkg::RSP_DEPTH),
      .item_type(hbh_pkg::rsp_type)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(back_push),
      .push_data(back_rsp),
      .full(rsp_full),
      .pop(rsp_pop),
      .pop_data(out_rsp),
      .empty(rsp_empty)
   );

   assign req_full = cmd_full;
   assign rsp_feature_sum = out_rsp.feature_sum;
   assign rsp_feature_pos = out_rsp.feature_pos;
   assign rsp_block_id = out_rsp.block_id;
   assign rsp_status = out_rsp.status;
   assign rsp_last = out_rsp.last;

endmodule

/* src/hbh_fifo.sv */
// Small first-in first-out queue used between the parts of the block.
module hbh_fifo #(
   parameter int unsigned DEPTH = 4,
   parameter type item_type = logic [7:0]
) (
   input logic clock,
   input logic reset,
   input logic push,
   input item_type push_data,
   output logic full,
   input logic pop,
   output item_type pop_data,
   output logic empty
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type slots_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == (PtrW + 1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/hbh_front.sv */
// Request decoder that classifies each request and drops the ones with no effect.
module hbh_front #(
   parameter int unsigned IMAGE_SIZE = 64,
   parameter int unsigned MAX_BLOCKS = 32
) (
   input logic req_push,
   input logic queue_full,
   input logic [1:0] req_op,
   input logic [5:0] req_pixel_row,
   input logic [5:0] req_pixel_col,
   input logic [15:0] req_magnitude,
   input logic [14:0] req_angle,
   input logic [4:0] req_block_slot,
   input logic [7:0] req_cell_row,
   input logic [7:0] req_cell_col,
   input logic [7:0] req_cells_high,
   input logic [7:0] req_cells_wide,
   output logic cmd_push,
   output hbh_pkg::cmd_type cmd
);

   logic keep;
   logic pixel_ok;
   logic slot_ok;

   assign pixel_ok = (32'(req_pixel_row) < IMAGE_SIZE) && (32'(req_pixel_col) < IMAGE_SIZE);
   assign slot_ok = (32'(req_block_slot) < MAX_BLOCKS);

   always_comb begin
      cmd.row = req_pixel_row;
      cmd.col = req_pixel_col;
      cmd.magnitude = req_magnitude;
      cmd.angle = req_angle;
      cmd.slot = req_block_slot;
      cmd.desc = {req_cells_wide, req_cells_high, req_cell_col, req_cell_row};
      cmd.kind = hbh_pkg::KIND_REJECT;
      keep = 1'b0;
      unique case (req_op)
         hbh_pkg::OP_PIXEL: begin
            cmd.kind = hbh_pkg::KIND_PIXEL;
            keep = pixel_ok;
         end
         hbh_pkg::OP_DESC: begin
            cmd.kind = hbh_pkg::KIND_DESC;
            keep = slot_ok;
         end
         hbh_pkg::OP_COMPUTE: begin
            cmd.kind = slot_ok ? hbh_pkg::KIND_COMPUTE : hbh_pkg::KIND_REJECT;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = req_push && !queue_full && keep;

endmodule

/* src/hbh_back.sv */
// Command engine holding the gradient window, the block table and the bin sums.
module hbh_back #(
   parameter int unsigned IMAGE_SIZE = 64,
   parameter int unsigned CELL_EDGE = 4,
   parameter int unsigned NUM_BINS = 10,
   parameter int unsigned MAX_BLOCKS = 32
) (
   input logic clock,
   input logic reset,
   input logic cmd_empty,
   input hbh_pkg::cmd_type cmd,
   output logic cmd_pop,
   input logic rsp_full,
   output logic rsp_push,
   output hbh_pkg::rsp_type rsp
);

   localparam int unsigned RowW = $clog2(IMAGE_SIZE);
   localparam int unsigned AddrW = $clog2(IMAGE_SIZE * IMAGE_SIZE);
   localparam int unsigned PixW = $clog2(CELL_EDGE);
   localparam int unsigned BinW = $clog2(NUM_BINS);
   localparam int unsigned PosW = $clog2(hbh_pkg::CELLS_PER_BLOCK * NUM_BINS);
   localparam int unsigned SlotW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned SumW = hbh_pkg::SUM_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DESC = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_CELL = 3'd3;
   localparam logic [2:0] S_PIX = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;
   localparam logic [2:0] S_ERR = 3'd7;

   logic [30:0] pix_mem [IMAGE_SIZE * IMAGE_SIZE];
   logic [31:0] tbl_mem [MAX_BLOCKS];

   logic [2:0] state_ff, state_in;
   logic [MAX_BLOCKS-1:0] tbl_vld_ff, tbl_vld_in;
   logic rd_vld_ff, rd_vld_in;
   logic [30:0] pix_rd_ff;
   logic [31:0] tbl_rd_ff;
   logic tbl_hit_ff;
   logic [hbh_pkg::ID_W-1:0] slot_ff, slot_in;
   logic [7:0] crow_ff, crow_in, ccol_ff, ccol_in, ch_ff, ch_in, cw_ff, cw_in;
   logic [1:0] ci_ff, ci_in, cj_ff, cj_in;
   logic [RowW-1:0] row0_ff, row0_in, col0_ff, col0_in;
   logic [PixW-1:0] pr_ff, pr_in, pc_ff, pc_in;
   logic [BinW-1:0] bin_ff, bin_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [SumW-1:0] acc_ff [NUM_BINS];
   logic [SumW-1:0] acc_in [NUM_BINS];

   logic pix_we, tbl_we;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [SlotW-1:0] tbl_addr;
   logic [31:0] desc_word;
   logic desc_bad;
   logic [15:0] rd_mag;
   logic [14:0] rd_ang;
   logic [NUM_BINS:0] ge;
   logic [NUM_BINS-1:0] hit;
   logic last_pos;

   assign rd_mag = pix_rd_ff[30:15];
   assign rd_ang = pix_rd_ff[14:0];

   assign ge[0] = 1'b1;
   for (genvar g = 1; g < NUM_BINS; g++) begin : g_thr
      localparam int unsigned Thr = (g * hbh_pkg::FULL_TURN + NUM_BINS - 1) / NUM_BINS;
      assign ge[g] = (32'(rd_ang) >= Thr);
   end
   assign ge[NUM_BINS] = (32'(rd_ang) >= hbh_pkg::FULL_TURN);
   assign hit = ge[NUM_BINS-1:0] & ~ge[NUM_BINS:1];

   assign wr_addr = AddrW'(32'(cmd.row) * IMAGE_SIZE + 32'(cmd.col));
   assign rd_addr = AddrW'(32'(row0_ff + RowW'(pr_ff)) * IMAGE_SIZE
                           + 32'(col0_ff + RowW'(pc_ff)));
   assign tbl_addr = SlotW'(cmd.slot);
   assign desc_word = tbl_hit_ff ? tbl_rd_ff : '0;
   assign last_pos = (pos_ff == PosW'(hbh_pkg::CELLS_PER_BLOCK * NUM_BINS - 1));

   assign desc_bad = (16'(ch_ff) * 16'(cw_ff) != 16'(hbh_pkg::CELLS_PER_BLOCK))
                     || ((32'(crow_ff) + 32'(ch_ff)) * CELL_EDGE > IMAGE_SIZE)
                     || ((32'(ccol_ff) + 32'(cw_ff)) * CELL_EDGE > IMAGE_SIZE);

   always_comb begin
      state_in = state_ff;
      tbl_vld_in = tbl_vld_ff;
      rd_vld_in = 1'b0;
      slot_in = slot_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      ch_in = ch_ff;
      cw_in = cw_ff;
      ci_in = ci_ff;
      cj_in = cj_ff;
      row0_in = row0_ff;
      col0_in = col0_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      bin_in = bin_ff;
      pos_in = pos_ff;
      cmd_pop = 1'b0;
      pix_we = 1'b0;
      tbl_we = 1'b0;
      rsp_push = 1'b0;
      rsp.feature_sum = acc_ff[bin_ff];
      rsp.feature_pos = hbh_pkg::POS_W'(pos_ff);
      rsp.block_id = slot_ff;
      rsp.status = 1'b0;
      rsp.last = last_pos;

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               slot_in = cmd.slot;
               unique case (cmd.kind)
                  hbh_pkg::KIND_PIXEL: begin
                     pix_we = 1'b1;
                  end
                  hbh_pkg::KIND_DESC: begin
                     tbl_we = 1'b1;
                     tbl_vld_in[tbl_addr] = 1'b1;
                  end
                  hbh_pkg::KIND_COMPUTE: begin
                     state_in = S_DESC;
                  end
                  default: begin
                     state_in = S_ERR;
                  end
               endcase
            end
         end
         S_DESC: begin
            crow_in = desc_word[7:0];
            ccol_in = desc_word[15:8];
            ch_in = desc_word[23:16];
            cw_in = desc_word[31:24];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            ci_in = '0;
            cj_in = '0;
            pos_in = '0;
            state_in = desc_bad ? S_ERR : S_CELL;
         end
         S_CELL: begin
            row0_in = RowW'((32'(crow_ff) + 32'(ci_ff)) * CELL_EDGE);
            col0_in = RowW'((32'(ccol_ff) + 32'(cj_ff)) * CELL_EDGE);
            pr_in = '0;
            pc_in = '0;
            state_in = S_PIX;
         end
         S_PIX: begin
            rd_vld_in = 1'b1;
            if (pc_ff == PixW'(CELL_EDGE - 1)) begin
               pc_in = '0;
               pr_in = pr_ff + 1'b1;
               if (pr_ff == PixW'(CELL_EDGE - 1)) begin
                  state_in = S_DRAIN;
               end
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            bin_in = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               pos_in = pos_ff + 1'b1;
               if (bin_ff == BinW'(NUM_BINS - 1)) begin
                  bin_in = '0;
                  if (8'(cj_ff) + 8'd1 == cw_ff) begin
                     cj_in = '0;
                     ci_in = ci_ff + 1'b1;
                  end else begin
                     cj_in = cj_ff + 1'b1;
                  end
                  state_in = last_pos ? S_IDLE : S_CELL;
               end else begin
                  bin_in = bin_ff + 1'b1;
               end
            end
         end
         S_ERR: begin
            rsp.feature_sum = '0;
            rsp.feature_pos = '0;
            rsp.status = 1'b1;
            rsp.last = 1'b1;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic [SumW:0] sum;
      for (int b = 0; b < NUM_BINS; b++) begin
         sum = {1'b0, acc_ff[b]} + (SumW + 1)'(rd_mag);
         acc_in[b] = acc_ff[b];
         if (state_ff == S_CELL) begin
            acc_in[b] = '0;
         end else if (rd_vld_ff && hit[b]) begin
            acc_in[b] = sum[SumW] ? '1 : sum[SumW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tbl_vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tbl_vld_ff <= tbl_vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      crow_ff <= crow_in;
      ccol_ff <= ccol_in;
      ch_ff <= ch_in;
      cw_ff <= cw_in;
      ci_ff <= ci_in;
      cj_ff <= cj_in;
      row0_ff <= row0_in;
      col0_ff <= col0_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      bin_ff <= bin_in;
      pos_ff <= pos_in;
      for (int b = 0; b < NUM_BINS; b++) begin
         acc_ff[b] <= acc_in[b];
      end
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[wr_addr] <= {cmd.magnitude, cmd.angle};
      end
      pix_rd_ff <= pix_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_addr] <= cmd.desc;
      end
      tbl_rd_ff <= tbl_mem[tbl_addr];
      tbl_hit_ff <= tbl_vld_ff[tbl_addr];
   end

endmodule

/* src/hbh_checker.sv */
// Port-level checks of the block histogram unit and their binding to it.
`include "assert_macros.svh"

module hbh_checker (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input logic [19:0] rsp_feature_sum,
   input logic [5:0] rsp_feature_pos,
   input logic [4:0] rsp_block_id,
   input logic rsp_status,
   input logic rsp_last
);

   `HBH_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (rsp_empty && !req_full), "queues not empty after reset")
   `HBH_ASSERT(a_rsp_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_feature_sum) && $stable(rsp_feature_pos)), "waiting result changed")
   `HBH_ASSERT(a_pos_steps, clock, reset, (!rsp_empty && rsp_pop && !rsp_status && !rsp_last) |=> (rsp_empty || rsp_feature_pos == 6'($past(rsp_feature_pos) + 6'd1)), "feature position skipped")
   `HBH_ASSERT(a_block_continues, clock, reset, (!rsp_empty && rsp_pop && !rsp_last) |=> (rsp_empty || (!rsp_status && rsp_block_id == $past(rsp_block_id))), "block features interrupted")

endmodule

bind hog_block_histogram hbh_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_feature_sum(rsp_feature_sum),
   .rsp_feature_pos(rsp_feature_pos),
   .rsp_block_id(rsp_block_id),
   .rsp_status(rsp_status),
   .rsp_last(rsp_last)
);
